/* hw/rtl/lsq_pkg.sv */
// Shared types and constants for the linked slot queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package lsq_pkg;

	// Width of the dequeued payload on the result port.
	localparam int unsigned OUT_W = 32;

	// The retire list holds up to three entries; a dequeue adds one while there is room.
	localparam int unsigned RET_DEPTH = 3;
	localparam int unsigned RET_CW    = 2;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	// One datapath operation per cycle, chosen by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_RCL_STEP,
		OP_RCL_END,
		OP_SCAN_FIRST,
		OP_SCAN_CHECK,
		OP_ALLOC,
		OP_WALK_FIRST,
		OP_WALK_CHECK,
		OP_LINK,
		OP_DEQ_READ,
		OP_DEQ_CHECK,
		OP_DEQ_DATA
	} lsq_op_t;

	typedef struct packed {
		lsq_op_t op;
	} lsq_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic rcl_more;
		logic scan_free;
		logic scan_last;
		logic walk_stop;
		logic deq_empty;
	} lsq_stat_t;

endpackage

/* hw/rtl/lsq_ram.sv */
// Generic single-write, single-read memory with a registered read port.
// Stand-alone; holds no reset and needs no package.
`timescale 1ns / 1ps

module lsq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/lsq_ctrl.sv */
// Controller state machine of the linked slot queue.
// Depends on lsq_pkg; drives the datapath operation and the result strobe.
`timescale 1ns / 1ps

module lsq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              cmd,
	output logic              busy,
	output logic              done,
	output logic              status,
	output lsq_pkg::lsq_cmd_t ctl,
	input  lsq_pkg::lsq_stat_t st
);

	import lsq_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RCL,
		S_SCAN_RD,
		S_SCAN_CK,
		S_ALLOC,
		S_WALK_RD,
		S_WALK_CK,
		S_LINK,
		S_DEQ_RD,
		S_DEQ_CK,
		S_DEQ_DATA
	} state_t;

	state_t state_q;
	logic   cmd_q;
	logic   second_q;
	logic   done_q;
	logic   status_q;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;

	always_comb begin
		ctl.op = OP_NONE;
		unique case (state_q)
			S_CLEAR:    ctl.op = OP_CLEAR;
			S_IDLE:     ctl.op = start ? OP_LOAD : OP_NONE;
			S_RCL:      ctl.op = st.rcl_more ? OP_RCL_STEP : OP_RCL_END;
			S_SCAN_RD:  ctl.op = OP_SCAN_FIRST;
			S_SCAN_CK:  ctl.op = OP_SCAN_CHECK;
			S_ALLOC:    ctl.op = OP_ALLOC;
			S_WALK_RD:  ctl.op = OP_WALK_FIRST;
			S_WALK_CK:  ctl.op = OP_WALK_CHECK;
			S_LINK:     ctl.op = OP_LINK;
			S_DEQ_RD:   ctl.op = OP_DEQ_READ;
			S_DEQ_CK:   ctl.op = OP_DEQ_CHECK;
			S_DEQ_DATA: ctl.op = OP_DEQ_DATA;
			default:    ctl.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cmd_q    <= CMD_ENQ;
			second_q <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (st.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q    <= cmd;
						second_q <= 1'b0;
						state_q  <= S_RCL;
					end
				end
				S_RCL: begin
					if (!st.rcl_more) begin
						// A dequeue runs the reclaim a second time after retiring the old dummy.
						if (second_q) begin
							done_q   <= 1'b1;
							status_q <= ST_OK;
							state_q  <= S_IDLE;
						end else if (cmd_q == CMD_DEQ) begin
							state_q <= S_DEQ_RD;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CK;
				S_SCAN_CK: begin
					if (st.scan_free) begin
						state_q <= S_ALLOC;
					end else if (st.scan_last) begin
						done_q   <= 1'b1;
						status_q <= ST_FAIL;
						state_q  <= S_IDLE;
					end
				end
				S_ALLOC:   state_q <= S_WALK_RD;
				S_WALK_RD: state_q <= S_WALK_CK;
				S_WALK_CK: begin
					if (st.walk_stop) begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					state_q  <= S_IDLE;
				end
				S_DEQ_RD: state_q <= S_DEQ_CK;
				S_DEQ_CK: begin
					if (st.deq_empty) begin
						done_q   <= 1'b1;
						status_q <= ST_FAIL;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_DEQ_DATA;
					end
				end
				S_DEQ_DATA: begin
					second_q <= 1'b1;
					state_q  <= S_RCL;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/lsq_dpath.sv */
// Datapath of the linked slot queue: slot link and payload memories, list
// pointers, hazard registers and the retire list. Depends on lsq_pkg and lsq_ram.
`timescale 1ns / 1ps

module lsq_dpath #(
	parameter int unsigned SLOTS      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [DATA_WIDTH-1:0]       data_in,
	output logic [lsq_pkg::OUT_W-1:0]   data_out,
	input  lsq_pkg::lsq_cmd_t           ctl,
	output lsq_pkg::lsq_stat_t          st
);

	import lsq_pkg::*;

	localparam int unsigned IW = $clog2(SLOTS);
	localparam int unsigned PW = IW + 1;
	localparam int unsigned LW = IW + 2;
	localparam logic [PW-1:0] NIL  = PW'(SLOTS);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	// Link entry: used flag, no-next flag, next index.
	localparam int unsigned L_USED = LW - 1;
	localparam int unsigned L_NIL  = LW - 2;

	logic [IW-1:0]         clr_q;
	logic [IW-1:0]         head_q;
	logic [IW-1:0]         tail_q;
	logic [IW-1:0]         sp_q;
	logic [PW-1:0]         haz0_q;
	logic [PW-1:0]         haz1_q;
	logic [IW-1:0]         ret_q [RET_DEPTH];
	logic [RET_CW-1:0]     ret_cnt_q;
	logic [RET_CW-1:0]     rcl_rd_q;
	logic [RET_CW-1:0]     rcl_kept_q;
	logic [IW-1:0]         scan_q;
	logic [IW-1:0]         scan_cnt_q;
	logic [IW-1:0]         node_q;
	logic [IW-1:0]         walk_q;
	logic                  walk_used_q;
	logic [PW-1:0]         moves_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] dout_q;

	logic                  link_we;
	logic [IW-1:0]         link_waddr;
	logic [LW-1:0]         link_wdata;
	logic [IW-1:0]         link_raddr;
	logic [LW-1:0]         link_rd;
	logic [DATA_WIDTH-1:0] pay_rd;

	logic [IW-1:0]         rd_idx;
	logic                  rd_nil;
	logic [IW-1:0]         rcl_e;
	logic                  rcl_keep;
	logic [IW-1:0]         scan_nxt;

	assign rd_idx   = link_rd[IW-1:0];
	assign rd_nil   = link_rd[L_NIL];
	assign rcl_e    = ret_q[rcl_rd_q];
	assign rcl_keep = ({1'b0, rcl_e} == haz0_q) || ({1'b0, rcl_e} == haz1_q);
	assign scan_nxt = (scan_q == LAST) ? '0 : scan_q + IW'(1);

	assign st.clr_last  = (clr_q == LAST);
	assign st.rcl_more  = (rcl_rd_q < ret_cnt_q);
	assign st.scan_free = !link_rd[L_USED];
	assign st.scan_last = (scan_cnt_q == LAST);
	assign st.walk_stop = rd_nil || (moves_q == NIL);
	assign st.deq_empty = rd_nil;

	always_comb begin
		link_we    = 1'b0;
		link_waddr = walk_q;
		link_wdata = {1'b0, 1'b1, {IW{1'b0}}};
		link_raddr = walk_q;
		case (ctl.op)
			OP_CLEAR: begin
				link_we    = 1'b1;
				link_waddr = clr_q;
				link_wdata = {(clr_q == '0), 1'b1, {IW{1'b0}}};
			end
			OP_RCL_STEP: begin
				link_we    = !rcl_keep;
				link_waddr = rcl_e;
			end
			OP_SCAN_FIRST: link_raddr = sp_q;
			OP_SCAN_CHECK: link_raddr = scan_nxt;
			OP_ALLOC: begin
				link_we    = 1'b1;
				link_waddr = scan_q;
				link_wdata = {1'b1, 1'b1, {IW{1'b0}}};
			end
			OP_WALK_CHECK: link_raddr = rd_idx;
			OP_LINK: begin
				link_we    = 1'b1;
				link_waddr = walk_q;
				link_wdata = {walk_used_q, 1'b0, node_q};
			end
			OP_DEQ_READ: link_raddr = head_q;
			default: ;
		endcase
	end

	lsq_ram #(
		.WIDTH(LW),
		.DEPTH(SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(link_raddr),
		.rdata(link_rd)
	);

	// The payload read follows the next index just read from the head slot.
	lsq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(SLOTS)
	) u_pay_ram (
		.clk  (clk),
		.we   (ctl.op == OP_ALLOC),
		.waddr(scan_q),
		.wdata(data_q),
		.raddr(rd_idx),
		.rdata(pay_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			sp_q       <= '0;
			haz0_q     <= NIL;
			haz1_q     <= NIL;
			ret_cnt_q  <= '0;
			rcl_rd_q   <= '0;
			rcl_kept_q <= '0;
		end else begin
			case (ctl.op) inside
				OP_CLEAR: clr_q <= clr_q + IW'(1);
				OP_LOAD, OP_DEQ_DATA: begin
					rcl_rd_q   <= '0;
					rcl_kept_q <= '0;
				end
				OP_RCL_STEP: begin
					rcl_rd_q <= rcl_rd_q + RET_CW'(1);
					if (rcl_keep) begin
						rcl_kept_q <= rcl_kept_q + RET_CW'(1);
					end
				end
				OP_RCL_END: ret_cnt_q <= rcl_kept_q;
				OP_ALLOC:   sp_q <= scan_q;
				OP_LINK: begin
					haz0_q <= {1'b0, walk_q};
					tail_q <= node_q;
				end
				OP_DEQ_CHECK: begin
					haz0_q <= {1'b0, head_q};
					haz1_q <= rd_nil ? NIL : {1'b0, rd_idx};
					if (!rd_nil) begin
						head_q <= rd_idx;
						if (tail_q == head_q) begin
							tail_q <= rd_idx;
						end
						if (ret_cnt_q != RET_CW'(RET_DEPTH)) begin
							ret_cnt_q <= ret_cnt_q + RET_CW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				data_q <= data_in;
				dout_q <= '0;
			end
			OP_RCL_STEP: begin
				// Kept entries move down in place, so order is preserved.
				if (rcl_keep) begin
					ret_q[rcl_kept_q] <= rcl_e;
				end
			end
			OP_SCAN_FIRST: begin
				scan_q     <= sp_q;
				scan_cnt_q <= '0;
			end
			OP_SCAN_CHECK: begin
				if (link_rd[L_USED]) begin
					scan_q     <= scan_nxt;
					scan_cnt_q <= scan_cnt_q + IW'(1);
				end
			end
			OP_ALLOC: begin
				node_q  <= scan_q;
				walk_q  <= tail_q;
				moves_q <= '0;
			end
			OP_WALK_CHECK: begin
				walk_used_q <= link_rd[L_USED];
				if (!(rd_nil || (moves_q == NIL))) begin
					walk_q  <= rd_idx;
					moves_q <= moves_q + PW'(1);
				end
			end
			OP_DEQ_CHECK: begin
				if (!rd_nil && (ret_cnt_q != RET_CW'(RET_DEPTH))) begin
					ret_q[ret_cnt_q] <= head_q;
				end
			end
			OP_DEQ_DATA: dout_q <= pay_rd;
			default: ;
		endcase
	end

	generate
		if (DATA_WIDTH >= OUT_W) begin : g_trunc
			assign data_out = dout_q[OUT_W-1:0];
		end else begin : g_ext
			assign data_out = {{(OUT_W - DATA_WIDTH){1'b0}}, dout_q};
		end
	endgenerate

endmodule

/* hw/rtl/linked_slot_queue_with_deferred_free.sv */
// Linked slot queue with deferred slot reclamation, one operation at a time.
// Enqueue checks retired entries, scans for a free slot testing one per cycle, allocates
// it, walks from the tail to the list end and links it; a full pool fails it. Dequeue
// reclaims, reads the head, fetches the payload and reclaims again, or fails on an empty
// queue. The next item is accepted from the cycle in which done is high. After reset a
// clearing pass initialises the link memory with busy high; done cannot be stalled.
`timescale 1ns / 1ps

module linked_slot_queue_with_deferred_free #(
	parameter int unsigned SLOTS      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      cmd,
	input  logic [DATA_WIDTH-1:0]     data_in,
	output logic                      done,
	output logic                      status,
	output logic [lsq_pkg::OUT_W-1:0] data_out
);

	import lsq_pkg::*;

	lsq_cmd_t  ctl;
	lsq_stat_t st;

	lsq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done),
		.status(status),
		.ctl   (ctl),
		.st    (st)
	);

	lsq_dpath #(
		.SLOTS     (SLOTS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.data_in (data_in),
		.data_out(data_out),
		.ctl     (ctl),
		.st      (st)
	);

endmodule
